[rtl/slsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slsm_pkg;

  localparam int LOG_DEPTH_DEF = 16;

  localparam int OP_W     = 3;
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 24;
  localparam int STAMP_W  = 16;
  localparam int BITIDX_W = 3;
  localparam int STATUS_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W  = KIND_W + STAMP_W + DATA_W;

  localparam int BIT_HEATER   = 0;
  localparam int BIT_FAN      = 1;
  localparam int BIT_LOG_FULL = 3;
  localparam int BIT_NIGHT    = 4;

  localparam logic signed [DATA_W-1:0] TEMP_HIGH_RST  = 24'sd7680;
  localparam logic signed [DATA_W-1:0] TEMP_LOW_RST   = 24'sd3840;
  localparam logic signed [DATA_W-1:0] HUMID_HIGH_RST = 24'sd17920;
  localparam logic signed [DATA_W-1:0] LIGHT_LOW_RST  = 24'sd51200;

  typedef enum logic [OP_W-1:0] {
    OP_LOG       = 3'd0,
    OP_POP       = 3'd1,
    OP_SET_BIT   = 3'd2,
    OP_CLR_BIT   = 3'd3,
    OP_TGL_BIT   = 3'd4,
    OP_TICK      = 3'd5,
    OP_CLEAR_ALL = 3'd6
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEMP  = 2'd0,
    KIND_HUMID = 2'd1,
    KIND_LIGHT = 2'd2,
    KIND_OTHER = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_HIGH  = 2'd0,
    CFG_TEMP_LOW   = 2'd1,
    CFG_HUMID_HIGH = 2'd2,
    CFG_LIGHT_LOW  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] temp_high;
    logic signed [DATA_W-1:0] temp_low;
    logic signed [DATA_W-1:0] humid_high;
    logic signed [DATA_W-1:0] light_low;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KIND_W-1:0]   kind;
    logic [DATA_W-1:0]   value;
    logic [BITIDX_W-1:0] bit_idx;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STAMP_W-1:0] stamp;
    logic [DATA_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_cmd_t;

  typedef struct packed {
    logic pop_ok;
    logic full;
  } ring_stat_t;

endpackage

`default_nettype wire

[rtl/slsm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module slsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/slsm_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module slsm_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             we_i,
  input  wire logic [slsm_pkg::CFG_IDX_W-1:0]   idx_i,
  input  wire logic [slsm_pkg::DATA_W-1:0]      data_i,
  output slsm_pkg::cfg_t                        cfg_o
);

  slsm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (slsm_pkg::cfg_idx_e'(idx_i))
        slsm_pkg::CFG_TEMP_HIGH:  cfg_d.temp_high  = $signed(data_i);
        slsm_pkg::CFG_TEMP_LOW:   cfg_d.temp_low   = $signed(data_i);
        slsm_pkg::CFG_HUMID_HIGH: cfg_d.humid_high = $signed(data_i);
        slsm_pkg::CFG_LIGHT_LOW:  cfg_d.light_low  = $signed(data_i);
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_high  <= slsm_pkg::TEMP_HIGH_RST;
      cfg_q.temp_low   <= slsm_pkg::TEMP_LOW_RST;
      cfg_q.humid_high <= slsm_pkg::HUMID_HIGH_RST;
      cfg_q.light_low  <= slsm_pkg::LIGHT_LOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/slsm_ring.sv]
`timescale 1ns / 1ps
`default_nettype none

module slsm_ring #(
  parameter int LOG_DEPTH = slsm_pkg::LOG_DEPTH_DEF,
  localparam int PTR_W = $clog2(LOG_DEPTH),
  localparam int CNT_W = $clog2(LOG_DEPTH + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire slsm_pkg::ring_cmd_t             cmd_i,
  input  wire logic [slsm_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [slsm_pkg::DATA_W-1:0]     value_i,
  input  wire logic [slsm_pkg::STAMP_W-1:0]    stamp_i,
  output slsm_pkg::entry_t                     entry_o,
  output slsm_pkg::ring_stat_t                 stat_o,
  output logic      [CNT_W-1:0]                count_o
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LOG_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(LOG_DEPTH - 1);

  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             byp_hit_q, byp_hit_d;
  slsm_pkg::entry_t byp_data_q, wdata, rdata;
  slsm_pkg::ring_stat_t stat;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  assign wdata.kind  = kind_i;
  assign wdata.stamp = stamp_i;
  assign wdata.value = value_i;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    stat  = '0;
    if (cmd_i.clear) begin
      wp_d  = '0;
      rp_d  = '0;
      cnt_d = '0;
    end else if (cmd_i.push) begin
      wp_d = ptr_next(wp_q);
      if (cnt_q < DEPTH_CNT) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        rp_d = ptr_next(rp_q);
      end
      stat.full = (cnt_d == DEPTH_CNT);
    end else if (cmd_i.pop && (cnt_q != '0)) begin
      rp_d        = ptr_next(rp_q);
      cnt_d       = cnt_q - 1'b1;
      stat.pop_ok = 1'b1;
    end
  end

  // read of the slot being written in the same cycle returns the new entry
  assign byp_hit_d = cmd_i.push && (wp_q == rp_d);

  slsm_ram #(
    .WIDTH (slsm_pkg::ENTRY_W),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .raddr_i (rp_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      cnt_q     <= '0;
      byp_hit_q <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      cnt_q     <= cnt_d;
      byp_hit_q <= byp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
  end

  assign entry_o = byp_hit_q ? byp_data_q : rdata;
  assign stat_o  = stat;
  assign count_o = cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("log count above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == DEPTH_CNT) |-> wp_q == rp_q)
    else $error("pointers apart while log empty or full");

endmodule

`default_nettype wire

[rtl/slsm_flags.sv]
`timescale 1ns / 1ps
`default_nettype none

module slsm_flags (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  wire slsm_pkg::item_t                  item_i,
  input  wire slsm_pkg::cfg_t                   cfg_i,
  input  wire logic                             full_i,
  output logic      [slsm_pkg::STATUS_W-1:0]    status_o,
  output logic      [slsm_pkg::STAMP_W-1:0]     tick_o
);

  logic [slsm_pkg::STATUS_W-1:0] status_q, status_d, bit_mask;
  logic [slsm_pkg::STAMP_W-1:0]  tick_q, tick_d;
  logic signed [slsm_pkg::DATA_W-1:0] val_s;

  assign val_s    = $signed(item_i.value);
  assign bit_mask = slsm_pkg::STATUS_W'(1) << item_i.bit_idx;

  always_comb begin
    status_d = status_q;
    tick_d   = tick_q;
    if (valid_i) begin
      unique case (slsm_pkg::op_e'(item_i.op))
        slsm_pkg::OP_LOG: begin
          case (slsm_pkg::kind_e'(item_i.kind))
            slsm_pkg::KIND_TEMP: begin
              status_d[slsm_pkg::BIT_FAN]    = (val_s > cfg_i.temp_high);
              status_d[slsm_pkg::BIT_HEATER] = (val_s < cfg_i.temp_low);
            end
            slsm_pkg::KIND_HUMID: begin
              if (val_s > cfg_i.humid_high) begin
                status_d[slsm_pkg::BIT_FAN] = 1'b1;
              end
            end
            slsm_pkg::KIND_LIGHT: begin
              status_d[slsm_pkg::BIT_NIGHT] = (val_s < cfg_i.light_low);
            end
            default: ;
          endcase
          status_d[slsm_pkg::BIT_LOG_FULL] = full_i;
        end
        slsm_pkg::OP_SET_BIT:   status_d = status_q | bit_mask;
        slsm_pkg::OP_CLR_BIT:   status_d = status_q & ~bit_mask;
        slsm_pkg::OP_TGL_BIT:   status_d = status_q ^ bit_mask;
        slsm_pkg::OP_TICK:      tick_d   = tick_q + 1'b1;
        slsm_pkg::OP_CLEAR_ALL: begin
          status_d = '0;
          tick_d   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      tick_q   <= '0;
    end else begin
      status_q <= status_d;
      tick_q   <= tick_d;
    end
  end

  assign status_o = status_q;
  assign tick_o   = tick_q;

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && item_i.op == slsm_pkg::OP_CLEAR_ALL |=> tick_q == '0 && status_q == '0)
    else $error("clear all left status or tick set");

endmodule

`default_nettype wire

[rtl/sensor_log_status_monitor.sv]
`timescale 1ns / 1ps
`default_nettype none

// sensor log and status monitor
// command channel: drive operation_i, sensor_kind_i, reading_value_i and bit_index_i
// with start_i high; the transaction is taken at that clock edge when busy_o is low.
// busy_o stays low, so a new command can be issued in every cycle.
// result channel: done_o is high for exactly one cycle per command, with status_bits_o,
// pop_valid_o, popped_kind_o, popped_stamp_o, popped_value_o and entries_held_o valid
// in that cycle; the receiver cannot stall, so the result must be taken then. one
// command gives one result, in order. the command passes the input register, then
// one pass of logic into the result registers; throughput: 1 command per cycle, set
// by the single log memory write port and the read from the next read pointer.
// limits are written through cfg_we_i / cfg_idx_i / cfg_data_i with no wait; the user
// must write them only while no command is in flight, which the block does not enforce.
// reset: log empty, pointers, status bits and tick at zero, limits at their
// defaults (30.0, 15.0, 70.0, 200.0 in Q15.8); the log memory is not cleared.

module sensor_log_status_monitor #(
  parameter int LOG_DEPTH = slsm_pkg::LOG_DEPTH_DEF,
  localparam int CNT_W = $clog2(LOG_DEPTH + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [slsm_pkg::OP_W-1:0]        operation_i,
  input  wire logic [slsm_pkg::KIND_W-1:0]      sensor_kind_i,
  input  wire logic signed [slsm_pkg::DATA_W-1:0] reading_value_i,
  input  wire logic [slsm_pkg::BITIDX_W-1:0]    bit_index_i,
  output logic                                  done_o,
  output logic      [slsm_pkg::STATUS_W-1:0]    status_bits_o,
  output logic                                  pop_valid_o,
  output logic      [slsm_pkg::KIND_W-1:0]      popped_kind_o,
  output logic      [slsm_pkg::STAMP_W-1:0]     popped_stamp_o,
  output logic signed [slsm_pkg::DATA_W-1:0]    popped_value_o,
  output logic      [CNT_W-1:0]                 entries_held_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [slsm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [slsm_pkg::DATA_W-1:0]      cfg_data_i
);

  logic                 valid_q, accept;
  slsm_pkg::item_t      item_q;
  slsm_pkg::cfg_t       cfg;
  slsm_pkg::ring_cmd_t  cmd;
  slsm_pkg::ring_stat_t stat;
  slsm_pkg::entry_t     entry;
  logic [slsm_pkg::STAMP_W-1:0] tick;

  logic                 done_q, pop_valid_q;
  slsm_pkg::entry_t     pop_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op      <= operation_i;
      item_q.kind    <= sensor_kind_i;
      item_q.value   <= reading_value_i;
      item_q.bit_idx <= bit_index_i;
    end
  end

  assign cmd.push  = valid_q && (item_q.op == slsm_pkg::OP_LOG);
  assign cmd.pop   = valid_q && (item_q.op == slsm_pkg::OP_POP);
  assign cmd.clear = valid_q && (item_q.op == slsm_pkg::OP_CLEAR_ALL);

  slsm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  slsm_ring #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .kind_i  (item_q.kind),
    .value_i (item_q.value),
    .stamp_i (tick),
    .entry_o (entry),
    .stat_o  (stat),
    .count_o (entries_held_o)
  );

  slsm_flags u_flags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_q),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .full_i   (stat.full),
    .status_o (status_bits_o),
    .tick_o   (tick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      pop_valid_q <= 1'b0;
    end else begin
      done_q      <= valid_q;
      pop_valid_q <= stat.pop_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_q <= stat.pop_ok ? entry : '0;
  end

  assign done_o         = done_q;
  assign pop_valid_o    = pop_valid_q;
  assign popped_kind_o  = pop_q.kind;
  assign popped_stamp_o = pop_q.stamp;
  assign popped_value_o = $signed(pop_q.value);

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(start_i, 2))
    else $error("result strobe without a transaction");

  a_pop_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid_q |-> done_q)
    else $error("pop flagged outside a result cycle");

endmodule

`default_nettype wire

[test/slsm_monitor_check.sv]
`timescale 1ns / 1ps

module slsm_monitor_check (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic                               busy_o,
  input  wire logic [slsm_pkg::OP_W-1:0]          operation_i,
  input  wire logic [slsm_pkg::KIND_W-1:0]        sensor_kind_i,
  input  wire logic [slsm_pkg::DATA_W-1:0]        reading_value_i,
  input  wire logic [slsm_pkg::BITIDX_W-1:0]      bit_index_i,
  input  wire logic                               done_o,
  input  wire logic [slsm_pkg::STATUS_W-1:0]      status_bits_o,
  input  wire logic                               pop_valid_o,
  input  wire logic [slsm_pkg::KIND_W-1:0]        popped_kind_o,
  input  wire logic [slsm_pkg::STAMP_W-1:0]       popped_stamp_o,
  input  wire logic [slsm_pkg::DATA_W-1:0]        popped_value_o,
  input  wire logic [4:0]                         entries_held_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [slsm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [slsm_pkg::DATA_W-1:0]        cfg_data_i,
  output int                                      mismatches,
  output int                                      pending,
  output int                                      checked,
  output int                                      pops_with_data,
  output int                                      overwrites
);

  import slsm_pkg::*;

  localparam int RING_SLOTS = LOG_DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pop_valid;
    logic [KIND_W-1:0]   kind;
    logic [STAMP_W-1:0]  stamp;
    logic [DATA_W-1:0]   value;
    logic [4:0]          held;
  } monitor_report_t;

  entry_t                   log_copy [RING_SLOTS];
  logic [3:0]               wr_slot;
  logic [3:0]               rd_slot;
  logic [4:0]               fill;
  logic [STATUS_W-1:0]      status_now;
  logic [STAMP_W-1:0]       tick_now;
  logic signed [DATA_W-1:0] lim_temp_high;
  logic signed [DATA_W-1:0] lim_temp_low;
  logic signed [DATA_W-1:0] lim_humid_high;
  logic signed [DATA_W-1:0] lim_light_low;
  monitor_report_t          awaited_reports [$];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic apply_monitor_op(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                                  input logic [DATA_W-1:0] raw,
                                  input logic [BITIDX_W-1:0] idx);
    monitor_report_t     r;
    logic signed [DATA_W-1:0] v;
    logic [STATUS_W-1:0] mask;
    r = '0;
    v = raw;
    mask = 8'd1 << idx;
    case (op)
      OP_LOG: begin
        log_copy[wr_slot].kind = kind;
        log_copy[wr_slot].stamp = tick_now;
        log_copy[wr_slot].value = raw;
        wr_slot = wr_slot + 4'd1;
        if (fill < RING_SLOTS) begin
          fill = fill + 5'd1;
        end else begin
          rd_slot = rd_slot + 4'd1;
          overwrites++;
        end
        case (kind)
          KIND_TEMP: begin
            status_now[BIT_FAN] = (v > lim_temp_high);
            status_now[BIT_HEATER] = (v < lim_temp_low);
          end
          KIND_HUMID: begin
            if (v > lim_humid_high) status_now[BIT_FAN] = 1'b1;
          end
          KIND_LIGHT: begin
            status_now[BIT_NIGHT] = (v < lim_light_low);
          end
          default: ;
        endcase
        status_now[BIT_LOG_FULL] = (fill == RING_SLOTS);
      end
      OP_POP: begin
        if (fill != 0) begin
          r.pop_valid = 1'b1;
          r.kind = log_copy[rd_slot].kind;
          r.stamp = log_copy[rd_slot].stamp;
          r.value = log_copy[rd_slot].value;
          rd_slot = rd_slot + 4'd1;
          fill = fill - 5'd1;
        end
      end
      OP_SET_BIT: status_now = status_now | mask;
      OP_CLR_BIT: status_now = status_now & ~mask;
      OP_TGL_BIT: status_now = status_now ^ mask;
      OP_TICK:    tick_now = tick_now + 16'd1;
      OP_CLEAR_ALL: begin
        wr_slot = '0;
        rd_slot = '0;
        fill = '0;
        status_now = '0;
        tick_now = '0;
      end
      default: ;
    endcase
    r.status = status_now;
    r.held = fill;
    awaited_reports.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    monitor_report_t want;
    if (!rst_ni) begin
      wr_slot = '0;
      rd_slot = '0;
      fill = '0;
      status_now = '0;
      tick_now = '0;
      lim_temp_high = TEMP_HIGH_RST;
      lim_temp_low = TEMP_LOW_RST;
      lim_humid_high = HUMID_HIGH_RST;
      lim_light_low = LIGHT_LOW_RST;
      awaited_reports.delete();
      mismatches = 0;
      pending = 0;
      checked = 0;
      pops_with_data = 0;
      overwrites = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEMP_HIGH:  lim_temp_high = cfg_data_i;
          CFG_TEMP_LOW:   lim_temp_low = cfg_data_i;
          CFG_HUMID_HIGH: lim_humid_high = cfg_data_i;
          CFG_LIGHT_LOW:  lim_light_low = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o)
        apply_monitor_op(operation_i, sensor_kind_i, reading_value_i, bit_index_i);
      if (done_o) begin
        if (awaited_reports.size() == 0) begin
          flag_mismatch("result transaction with no command waiting");
        end else begin
          want = awaited_reports.pop_front();
          checked++;
          if (want.pop_valid) pops_with_data++;
          if (status_bits_o !== want.status)
            flag_mismatch($sformatf("status_bits got %02h want %02h", status_bits_o,
                                    want.status));
          if (pop_valid_o !== want.pop_valid)
            flag_mismatch($sformatf("pop_valid got %b want %b", pop_valid_o, want.pop_valid));
          if (popped_kind_o !== want.kind)
            flag_mismatch($sformatf("popped_kind got %0d want %0d", popped_kind_o, want.kind));
          if (popped_stamp_o !== want.stamp)
            flag_mismatch($sformatf("popped_stamp got %04h want %04h", popped_stamp_o,
                                    want.stamp));
          if (popped_value_o !== want.value)
            flag_mismatch($sformatf("popped_value got %06h want %06h", popped_value_o,
                                    want.value));
          if (entries_held_o !== want.held)
            flag_mismatch($sformatf("entries_held got %0d want %0d", entries_held_o,
                                    want.held));
        end
      end
      pending = awaited_reports.size();
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

  import slsm_pkg::*;

  localparam logic [OP_W-1:0]          OP_UNUSED  = 3'd7;
  localparam int                       IDLE_LIMIT = 2000;
  localparam logic signed [DATA_W-1:0] VAL_MAX    = 24'sh7fffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN    = 24'sh800000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [OP_W-1:0]       operation_i;
  logic [KIND_W-1:0]     sensor_kind_i;
  logic [DATA_W-1:0]     reading_value_i;
  logic [BITIDX_W-1:0]   bit_index_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_bits_o;
  logic                  pop_valid_o;
  logic [KIND_W-1:0]     popped_kind_o;
  logic [STAMP_W-1:0]    popped_stamp_o;
  logic [DATA_W-1:0]     popped_value_o;
  logic [4:0]            entries_held_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [DATA_W-1:0]     cfg_data_i;

  int mismatches;
  int pending;
  int checked;
  int pops_with_data;
  int overwrites;
  int idle_cycles = 0;
  int sent = 0;
  logic signed [DATA_W-1:0] limits [4];

  sensor_log_status_monitor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .sensor_kind_i   (sensor_kind_i),
    .reading_value_i (reading_value_i),
    .bit_index_i     (bit_index_i),
    .done_o          (done_o),
    .status_bits_o   (status_bits_o),
    .pop_valid_o     (pop_valid_o),
    .popped_kind_o   (popped_kind_o),
    .popped_stamp_o  (popped_stamp_o),
    .popped_value_o  (popped_value_o),
    .entries_held_o  (entries_held_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  slsm_monitor_check check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .sensor_kind_i   (sensor_kind_i),
    .reading_value_i (reading_value_i),
    .bit_index_i     (bit_index_i),
    .done_o          (done_o),
    .status_bits_o   (status_bits_o),
    .pop_valid_o     (pop_valid_o),
    .popped_kind_o   (popped_kind_o),
    .popped_stamp_o  (popped_stamp_o),
    .popped_value_o  (popped_value_o),
    .entries_held_o  (entries_held_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatches      (mismatches),
    .pending         (pending),
    .checked         (checked),
    .pops_with_data  (pops_with_data),
    .overwrites      (overwrites)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                      input logic [DATA_W-1:0] val, input logic [BITIDX_W-1:0] idx,
                      input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= op;
    sensor_kind_i <= kind;
    reading_value_i <= val;
    bit_index_i <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic put_limit(input cfg_idx_e idx, input logic [DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic write_limits(input logic [DATA_W-1:0] temp_high,
                              input logic [DATA_W-1:0] temp_low,
                              input logic [DATA_W-1:0] humid_high,
                              input logic [DATA_W-1:0] light_low);
    put_limit(CFG_TEMP_HIGH, temp_high);
    put_limit(CFG_TEMP_LOW, temp_low);
    put_limit(CFG_HUMID_HIGH, humid_high);
    put_limit(CFG_LIGHT_LOW, light_low);
    cfg_we_i <= 1'b0;
    limits[CFG_TEMP_HIGH] = temp_high;
    limits[CFG_TEMP_LOW] = temp_low;
    limits[CFG_HUMID_HIGH] = humid_high;
    limits[CFG_LIGHT_LOW] = light_low;
  endtask

  // readings cluster at the extremes and right around the active limits
  function automatic logic [DATA_W-1:0] pick_reading();
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] offs;
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3, 4, 5: begin
        base = limits[$urandom_range(0, 3)];
        offs = DATA_W'($urandom_range(0, 4));
        return base + offs - 24'd2;
      end
      6, 7: begin
        offs = DATA_W'($urandom_range(0, 60000));
        return offs - 24'd2000;
      end
      default: begin
        offs = DATA_W'($urandom());
        return offs;
      end
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_LOG;
    if (r < 62) return OP_POP;
    if (r < 70) return OP_SET_BIT;
    if (r < 77) return OP_CLR_BIT;
    if (r < 85) return OP_TGL_BIT;
    if (r < 93) return OP_TICK;
    if (r < 97) return OP_CLEAR_ALL;
    return OP_UNUSED;
  endfunction

  // fill bursts of logs can push past a full ring, drain bursts of pops can run it empty, the rest is mixed
  task automatic random_phase(input int items);
    int target;
    int sel;
    int n;
    bit quiet;
    logic [OP_W-1:0] op;
    target = sent + items;
    while (sent < target) begin
      sel = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      n = (sel < 3) ? $urandom_range(14, 20) : (sel < 5) ? $urandom_range(1, 18)
                                                         : $urandom_range(4, 24);
      if (n > target - sent) n = target - sent;
      repeat (n) begin
        op = (sel < 3) ? OP_LOG : (sel < 5) ? OP_POP : pick_op();
        send(op, KIND_W'($urandom_range(0, 3)), pick_reading(),
             BITIDX_W'($urandom_range(0, 7)), quiet);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = '0;
    sensor_kind_i = '0;
    reading_value_i = '0;
    bit_index_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    limits[CFG_TEMP_HIGH] = TEMP_HIGH_RST;
    limits[CFG_TEMP_LOW] = TEMP_LOW_RST;
    limits[CFG_HUMID_HIGH] = HUMID_HIGH_RST;
    limits[CFG_LIGHT_LOW] = LIGHT_LOW_RST;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send(OP_POP, KIND_TEMP, '0, '0, 1'b0);
    send(OP_UNUSED, KIND_OTHER, VAL_MAX, 3'd7, 1'b0);
    send(OP_LOG, KIND_TEMP, TEMP_HIGH_RST, '0, 1'b0);
    send(OP_LOG, KIND_TEMP, TEMP_HIGH_RST + 24'sd1, '0, 1'b1);
    send(OP_LOG, KIND_TEMP, TEMP_LOW_RST - 24'sd1, '0, 1'b1);
    send(OP_LOG, KIND_TEMP, TEMP_LOW_RST, '0, 1'b0);
    send(OP_LOG, KIND_HUMID, HUMID_HIGH_RST + 24'sd1, '0, 1'b0);
    send(OP_LOG, KIND_HUMID, VAL_MIN, '0, 1'b1);
    send(OP_LOG, KIND_LIGHT, LIGHT_LOW_RST - 24'sd1, '0, 1'b0);
    send(OP_LOG, KIND_LIGHT, LIGHT_LOW_RST, '0, 1'b1);
    send(OP_TICK, KIND_OTHER, '0, '0, 1'b0);
    send(OP_LOG, KIND_OTHER, VAL_MAX, 3'd7, 1'b0);
    send(OP_LOG, KIND_OTHER, VAL_MIN, '0, 1'b1);
    send(OP_SET_BIT, KIND_TEMP, '0, 3'd7, 1'b0);
    send(OP_CLR_BIT, KIND_TEMP, '0, BITIDX_W'(BIT_HEATER), 1'b1);
    send(OP_TGL_BIT, KIND_TEMP, '0, 3'd2, 1'b0);
    send(OP_TGL_BIT, KIND_TEMP, '0, 3'd2, 1'b1);
    send(OP_SET_BIT, KIND_TEMP, '0, BITIDX_W'(BIT_LOG_FULL), 1'b0);
    send(OP_POP, KIND_TEMP, '0, '0, 1'b1);
    send(OP_POP, KIND_TEMP, '0, '0, 1'b0);
    send(OP_CLEAR_ALL, KIND_TEMP, '0, '0, 1'b0);
    send(OP_POP, KIND_TEMP, '0, '0, 1'b1);

    random_phase(120);
    settle();
    write_limits(DATA_W'($urandom_range(5000, 20000)), DATA_W'($urandom_range(0, 10000)),
                 DATA_W'($urandom_range(0, 30000)), DATA_W'($urandom_range(0, 70000)));
    random_phase(160);
    settle();
    write_limits(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX);
    random_phase(160);
    settle();
    write_limits(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN);
    random_phase(160);
    settle();
    write_limits(DATA_W'($urandom()), DATA_W'($urandom()), DATA_W'($urandom()),
                 DATA_W'($urandom()));
    random_phase(160);
    settle();
    write_limits(TEMP_HIGH_RST, TEMP_LOW_RST, HUMID_HIGH_RST, LIGHT_LOW_RST);
    random_phase(160);

    // a run of ticks after a clear, stamps read back by pops
    send(OP_CLEAR_ALL, KIND_TEMP, '0, '0, 1'b0);
    repeat (12) send(OP_TICK, KIND_OTHER, '0, '0, 1'b1);
    send(OP_LOG, KIND_TEMP, pick_reading(), '0, 1'b0);
    send(OP_TICK, KIND_OTHER, '0, '0, 1'b0);
    send(OP_LOG, KIND_HUMID, pick_reading(), '0, 1'b1);
    send(OP_POP, KIND_TEMP, '0, '0, 1'b0);
    send(OP_POP, KIND_TEMP, '0, '0, 1'b1);

    settle();
    repeat (8) @(posedge clk_i);
    $display("%0d commands sent over six limit settings and a tick run, %0d results checked",
             sent, checked);
    $display("%0d pops returned an entry, %0d logs overwrote the oldest entry of a full ring",
             pops_with_data, overwrites);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sensor_log_status_monitor.f]
rtl/slsm_pkg.sv
rtl/slsm_ram.sv
rtl/slsm_cfg.sv
rtl/slsm_ring.sv
rtl/slsm_flags.sv
rtl/sensor_log_status_monitor.sv
test/slsm_monitor_check.sv
test/tb.sv
